FILE: hdl/cpf_pkg.sv
// ----------------------------------------------------------------------------
// cpf_pkg: shared types and constants of the tax identifier checker
// Digit counts, BCD item layout, reason codes and the mod-11 helper.
// ----------------------------------------------------------------------------
package cpf_pkg;

    localparam int IdWidth    = 37;
    localparam int NumDigits  = 11;
    localparam int BcdWidth   = 4 * NumDigits;
    localparam int SumWidth   = 10;    // 9 * (11 + ... + 2) = 585
    localparam int InTdataW   = 40;
    localparam int OutTdataW  = 16;

    localparam logic [IdWidth-1:0] IdLow  = 37'd10000000000;
    localparam logic [IdWidth-1:0] IdHigh = 37'd99999999999;

    // floor(s / 11) == (s * Recip11) >> Recip11Shift for s < 1024
    localparam logic [9:0] Recip11      = 10'd745;
    localparam int         Recip11Shift = 13;

    typedef enum logic [2:0] {
        REASON_OK         = 3'd0,
        REASON_LENGTH     = 3'd1,
        REASON_ALL_EQUAL  = 3'd2,
        REASON_FIRST_BAD  = 3'd3,
        REASON_SECOND_BAD = 3'd4
    } reason_t;

    // Payload handed from cell to cell
    typedef struct packed {
        logic                bad;     // out of the eleven-digit range
        logic [BcdWidth-1:0] bcd;     // digits built so far, most significant first
        logic [IdWidth-1:0]  bits;    // binary bits still to shift in, msb first
    } cpf_item_t;

    // Check digit from a weighted sum: remainder below 2 gives 0, else 11 - r
    function automatic logic [3:0] check_digit(input logic [SumWidth-1:0] s);
        logic [19:0] prod;
        logic [6:0]  q;
        logic [10:0] q11;
        logic [3:0]  r;
        prod = s * Recip11;
        q    = prod[Recip11Shift +: 7];
        q11  = 11'(q) * 11'd11;
        r    = 4'(11'(s) - q11);
        if (r < 4'd2)
            check_digit = 4'd0;
        else
            check_digit = 4'd11 - r;
    endfunction

endpackage

FILE: hdl/cpf_dd_cell.sv
// ----------------------------------------------------------------------------
// cpf_dd_cell: one shift-and-add-3 step of the binary to BCD chain
// Adjusts every BCD digit and shifts in the next binary bit.
// ----------------------------------------------------------------------------
module cpf_dd_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  cpf_pkg::cpf_item_t item_in,
    output logic               valid_out,
    output cpf_pkg::cpf_item_t item_out
);
    import cpf_pkg::*;

    logic      valid_reg;
    cpf_item_t item_reg;
    cpf_item_t item_next;
    logic [BcdWidth-1:0] adj;

    always_comb
    begin
        for (int i = 0; i < NumDigits; i++)
        begin
            if (item_in.bcd[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = item_in.bcd[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = item_in.bcd[4*i +: 4];
        end
        item_next.bad  = item_in.bad;
        item_next.bcd  = {adj[BcdWidth-2:0], item_in.bits[IdWidth-1]};
        item_next.bits = {item_in.bits[IdWidth-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

FILE: hdl/cpf_check.sv
// ----------------------------------------------------------------------------
// cpf_check: weighted sums, mod-11 check digits and verdict
// Two register stages; the second one is the output register.
// ----------------------------------------------------------------------------
module cpf_check (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  cpf_pkg::cpf_item_t    item_in,
    output logic                  valid_out,
    output logic                  is_valid,
    output cpf_pkg::reason_t      reason,
    output logic [3:0]            first_check,
    output logic [3:0]            second_check
);
    import cpf_pkg::*;

    logic [3:0] dg [NumDigits];
    logic [SumWidth-1:0] s1_next, s2_next;
    logic same_next;

    // stage 1
    logic                valid1_reg;
    logic                bad_reg;
    logic                same_reg;
    logic [SumWidth-1:0] s1_reg, s2_reg;
    logic [3:0]          d9_reg, d10_reg;

    // stage 2
    logic       valid2_reg;
    logic       is_valid_reg;
    reason_t    reason_reg;
    logic [3:0] c1_reg, c2_reg;

    logic [3:0] c1, c2;
    reason_t    reason_next;

    always_comb
    begin
        for (int i = 0; i < NumDigits; i++)
            dg[i] = item_in.bcd[BcdWidth-1-4*i -: 4];
        same_next = 1'b1;
        for (int i = 1; i < NumDigits; i++)
            if (dg[i] != dg[0])
                same_next = 1'b0;
        s1_next = '0;
        s2_next = '0;
        for (int i = 0; i < 9; i++)
            s1_next = s1_next + SumWidth'(dg[i]) * SumWidth'(10 - i);
        for (int i = 0; i < 10; i++)
            s2_next = s2_next + SumWidth'(dg[i]) * SumWidth'(11 - i);
    end

    always_comb
    begin
        c1 = check_digit(s1_reg);
        c2 = check_digit(s2_reg);
        if (bad_reg)
            reason_next = REASON_LENGTH;
        else if (same_reg)
            reason_next = REASON_ALL_EQUAL;
        else if (c1 != d9_reg)
            reason_next = REASON_FIRST_BAD;
        else if (c2 != d10_reg)
            reason_next = REASON_SECOND_BAD;
        else
            reason_next = REASON_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= valid_in;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad_reg      <= item_in.bad;
            same_reg     <= same_next;
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            d9_reg       <= dg[9];
            d10_reg      <= dg[10];
            reason_reg   <= reason_next;
            is_valid_reg <= (reason_next == REASON_OK);
            c1_reg       <= bad_reg ? 4'd0 : c1;
            c2_reg       <= bad_reg ? 4'd0 : c2;
        end
    end

    assign valid_out    = valid2_reg;
    assign is_valid     = is_valid_reg;
    assign reason       = reason_reg;
    assign first_check  = c1_reg;
    assign second_check = c2_reg;

endmodule

FILE: hdl/cpf_check_digit_validator.sv
// ----------------------------------------------------------------------------
// cpf_check_digit_validator: eleven-digit tax identifier checker
// Converts the binary identifier to decimal through a chain of double-dabble
// cells, then forms both mod-11 check digits and reports a verdict.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload (tdata, lowest bit first)
//  s_axis    in   [36:0] id_number, [39:37] zero
//  m_axis    out  [0] is_valid, [3:1] reason, [7:4] first_check,
//                 [11:8] second_check, [15:12] zero
//
//  One request per cycle in and out while results are taken. Stages:
//  37 conversion cells (one per identifier bit), one sum stage and the
//  output register. The whole pipe advances together whenever the output
//  register is empty or being taken, so a stalled result freezes every
//  stage and s_axis_tready drops with it. Reset clears only the valid bits;
//  nothing needs a clearing pass.
//
module cpf_check_digit_validator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [cpf_pkg::InTdataW-1:0]   s_axis_tdata,   // [36:0] id_number
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [cpf_pkg::OutTdataW-1:0]  m_axis_tdata    // is_valid, reason,
                                                           // first_check, second_check
);
    import cpf_pkg::*;

    localparam int NumCells = IdWidth;

    logic                 en;
    logic [IdWidth-1:0]   id_number;
    cpf_item_t            head_item;
    logic                 valid_chain [NumCells+1];
    cpf_item_t            item_chain  [NumCells+1];

    logic       is_valid;
    reason_t    reason;
    logic [3:0] first_check;
    logic [3:0] second_check;

    // Advance the whole pipe when the output slot is free or being drained
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Range check up front; the cells carry the flag along
    assign id_number      = s_axis_tdata[IdWidth-1:0];
    assign head_item.bad  = (id_number < IdLow) || (id_number > IdHigh);
    assign head_item.bcd  = '0;
    assign head_item.bits = id_number;

    assign valid_chain[0] = s_axis_tvalid;
    assign item_chain[0]  = head_item;

    // One cell per binary bit, most significant bit first
    for (genvar g = 0; g < NumCells; g++)
    begin : g_cell
        cpf_dd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (valid_chain[g]),
            .item_in   (item_chain[g]),
            .valid_out (valid_chain[g+1]),
            .item_out  (item_chain[g+1])
        );
    end

    cpf_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .valid_in     (valid_chain[NumCells]),
        .item_in      (item_chain[NumCells]),
        .valid_out    (m_axis_tvalid),
        .is_valid     (is_valid),
        .reason       (reason),
        .first_check  (first_check),
        .second_check (second_check)
    );

    assign m_axis_tdata = {4'd0, second_check, first_check, reason, is_valid};

`ifndef SYNTH
    // Verdict bit agrees with the reason code
    a_valid_reason: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (is_valid == (reason == REASON_OK)))
        else $error("is_valid disagrees with reason");

    // Out-of-range identifiers report zero check digits
    a_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && reason == REASON_LENGTH) |->
        (first_check == 4'd0 && second_check == 4'd0))
        else $error("check digits not cleared for bad length");

    // Check digits stay decimal
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (first_check <= 4'd9 && second_check <= 4'd9))
        else $error("check digit out of range");

    // A stall freezes the conversion chain
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(valid_chain[NumCells]) && $stable(item_chain[NumCells])))
        else $error("conversion chain moved during stall");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the tax identifier checker
// Streams directed and random identifiers through the checker with random
// gaps on both sides, predicts every verdict and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import cpf_pkg::*;

    localparam int PipeLatency = 39;
    localparam int RandomItems = 900;
    localparam int HoldStart   = 300;      // results seen before the long hold
    localparam int HoldCycles  = 300;
    localparam int TimeoutNs   = 3000000;

    // Flavors of generated identifiers
    typedef enum int {
        GEN_VALID,
        GEN_BAD_FIRST,
        GEN_BAD_SECOND,
        GEN_ALL_EQUAL,
        GEN_IN_RANGE,
        GEN_ANY,
        GEN_LEADING_ZERO
    } id_kind_t;

    // Expected verdict, one per accepted request
    typedef struct packed {
        logic [3:0] second_check;
        logic [3:0] first_check;
        reason_t    reason;
        logic       is_valid;
    } cpf_verdict_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [InTdataW-1:0]  s_axis_tdata = '0;    // [36:0] id_number, [39:37] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OutTdataW-1:0] m_axis_tdata;         // [0] is_valid, [3:1] reason,
                                                // [7:4] first_check,
                                                // [11:8] second_check, [15:12] zero

    logic [IdWidth-1:0] pending_ids[$];
    cpf_verdict_t       expected_verdicts[$];
    cpf_verdict_t       oldest_verdict;

    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    int   in_wait   = 0;
    int   out_wait  = 0;
    int   rx_stall;
    int   cycle_count  = 0;
    int   results_seen = 0;
    int   fail_count   = 0;

    logic hold_active = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_cycles = 0;

    cpf_check_digit_validator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Mod-11 rule: remainder below 2 maps to 0, otherwise 11 minus remainder
    function automatic logic [3:0] mod11_digit(input int unsigned sum);
        int unsigned r;
        r = sum % 11;
        return (r < 2) ? 4'd0 : 4'(11 - r);
    endfunction

    // Compute the verdict the checker must give for one identifier
    function automatic cpf_verdict_t predict_verdict(input logic [IdWidth-1:0] id);
        logic [63:0]  rest;
        int unsigned  dg[NumDigits];
        int unsigned  s1;
        int unsigned  s2;
        bit           same;
        cpf_verdict_t v;
        v = '0;
        if (id < IdLow || id > IdHigh)
        begin
            v.reason = REASON_LENGTH;
            return v;
        end
        rest = 64'(id);
        for (int i = NumDigits - 1; i >= 0; i--)
        begin
            dg[i] = int'(rest % 10);
            rest  = rest / 10;
        end
        same = 1'b1;
        for (int i = 1; i < NumDigits; i++)
            if (dg[i] != dg[0])
                same = 1'b0;
        s1 = 0;
        s2 = 0;
        for (int i = 0; i < 9; i++)
            s1 += dg[i] * (10 - i);
        for (int i = 0; i < 10; i++)
            s2 += dg[i] * (11 - i);
        v.first_check  = mod11_digit(s1);
        v.second_check = mod11_digit(s2);
        if (same)
            v.reason = REASON_ALL_EQUAL;
        else if (v.first_check != dg[9])
            v.reason = REASON_FIRST_BAD;
        else if (v.second_check != dg[10])
            v.reason = REASON_SECOND_BAD;
        else
            v.reason = REASON_OK;
        v.is_valid = (v.reason == REASON_OK);
        return v;
    endfunction

    // Build one identifier of the requested flavor with random digits
    function automatic logic [IdWidth-1:0] make_id(input id_kind_t kind);
        int unsigned dg[NumDigits];
        int unsigned s1;
        int unsigned s2;
        int unsigned fill;
        logic [63:0] acc;
        case (kind)
            GEN_IN_RANGE:
                return IdWidth'({$urandom, $urandom} % (IdHigh - IdLow + 1) + IdLow);
            GEN_ANY:
                return IdWidth'({$urandom, $urandom});
            default: ;
        endcase
        dg[0] = (kind == GEN_LEADING_ZERO) ? 0 : $urandom_range(1, 9);
        for (int i = 1; i < 9; i++)
            dg[i] = $urandom_range(0, 9);
        s1 = 0;
        for (int i = 0; i < 9; i++)
            s1 += dg[i] * (10 - i);
        dg[9] = mod11_digit(s1);
        if (kind == GEN_BAD_FIRST)
            dg[9] = (dg[9] + $urandom_range(1, 9)) % 10;
        // second check digit follows the tenth digit as it now stands
        s2 = 0;
        for (int i = 0; i < 10; i++)
            s2 += dg[i] * (11 - i);
        dg[10] = mod11_digit(s2);
        if (kind == GEN_BAD_SECOND)
            dg[10] = (dg[10] + $urandom_range(1, 9)) % 10;
        if (kind == GEN_ALL_EQUAL)
        begin
            fill = $urandom_range(1, 9);
            for (int i = 0; i < NumDigits; i++)
                dg[i] = fill;
        end
        acc = '0;
        for (int i = 0; i < NumDigits; i++)
            acc = acc * 10 + dg[i];
        return IdWidth'(acc);
    endfunction

    // Gap drawn per request; every fourth window of the cycle counter runs flat out
    function automatic int draw_gap();
        return (((cycle_count / 500) % 4) == 3) ? 0 : $urandom_range(0, 9);
    endfunction

    // Sample both handshakes at the rising edge; predict on input, check on output
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        in_taken    <= s_axis_tvalid && s_axis_tready;
        out_taken   <= m_axis_tvalid && m_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_verdicts.push_back(predict_verdict(s_axis_tdata[IdWidth-1:0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen = results_seen + 1;
                if (expected_verdicts.size() == 0)
                begin
                    $error("result with no pending request: tdata %h", m_axis_tdata);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    oldest_verdict = expected_verdicts.pop_front();
                    if (m_axis_tdata[0] !== oldest_verdict.is_valid)
                    begin
                        $error("is_valid mismatch: expected %0d, actual %0d",
                               oldest_verdict.is_valid, m_axis_tdata[0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[3:1] !== oldest_verdict.reason)
                    begin
                        $error("reason mismatch: expected %0d, actual %0d",
                               oldest_verdict.reason, m_axis_tdata[3:1]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[7:4] !== oldest_verdict.first_check)
                    begin
                        $error("first_check mismatch: expected %0d, actual %0d",
                               oldest_verdict.first_check, m_axis_tdata[7:4]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[11:8] !== oldest_verdict.second_check)
                    begin
                        $error("second_check mismatch: expected %0d, actual %0d",
                               oldest_verdict.second_check, m_axis_tdata[11:8]);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    // Sender: hold a request until taken, then idle for its drawn gap
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_taken)
            begin
                // hold the current request
            end
            else if (in_wait != 0)
            begin
                s_axis_tvalid <= 1'b0;
                in_wait       <= in_wait - 1;
            end
            else if (pending_ids.size() != 0)
            begin
                s_axis_tdata  <= InTdataW'(pending_ids.pop_front());
                s_axis_tvalid <= 1'b1;
                in_wait       <= draw_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: after each result taken, drop ready for a drawn stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                rx_stall = draw_gap();
                out_wait      <= rx_stall;
                m_axis_tready <= (rx_stall == 0) && !hold_active;
            end
            else if (out_wait != 0)
            begin
                out_wait      <= out_wait - 1;
                m_axis_tready <= (out_wait == 1) && !hold_active;
            end
            else
                m_axis_tready <= !hold_active;
        end
    end

    // Long receiver hold-off, once: the pipe fills and the input must stall
    always @(negedge clk)
    begin
        if (rst_n && !hold_done && results_seen >= HoldStart)
        begin
            if (hold_cycles == HoldCycles)
            begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end
            else
            begin
                hold_active <= 1'b1;
                hold_cycles <= hold_cycles + 1;
            end
        end
    end

    initial
    begin
        int unsigned pick;
        // Directed: range edges, all-ones input, all-equal digits
        pending_ids.push_back('0);
        pending_ids.push_back(37'd1);
        pending_ids.push_back(IdLow - 37'd1);
        pending_ids.push_back(IdLow);
        pending_ids.push_back(IdHigh);
        pending_ids.push_back(IdHigh + 37'd1);
        pending_ids.push_back({IdWidth{1'b1}});
        pending_ids.push_back(37'd11111111111);
        pending_ids.push_back(37'd55555555555);
        // hand-picked identifier and single-digit corruptions of both checks
        pending_ids.push_back(37'd52998224725);
        pending_ids.push_back(37'd52998224735);
        pending_ids.push_back(37'd52998224724);
        // two of every generated flavor but the in-range one
        for (int k = 0; k < 2; k++)
        begin
            pending_ids.push_back(make_id(GEN_VALID));
            pending_ids.push_back(make_id(GEN_BAD_FIRST));
            pending_ids.push_back(make_id(GEN_BAD_SECOND));
            pending_ids.push_back(make_id(GEN_ALL_EQUAL));
            pending_ids.push_back(make_id(GEN_LEADING_ZERO));
            pending_ids.push_back(make_id(GEN_ANY));
        end
        // Random: mostly well-formed identifiers, the rest noise
        for (int n = 0; n < RandomItems; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                pending_ids.push_back(make_id(GEN_VALID));
            else if (pick < 60)
                pending_ids.push_back(make_id(GEN_BAD_FIRST));
            else if (pick < 72)
                pending_ids.push_back(make_id(GEN_BAD_SECOND));
            else if (pick < 77)
                pending_ids.push_back(make_id(GEN_ALL_EQUAL));
            else if (pick < 85)
                pending_ids.push_back(make_id(GEN_IN_RANGE));
            else if (pick < 93)
                pending_ids.push_back(make_id(GEN_ANY));
            else
                pending_ids.push_back(make_id(GEN_LEADING_ZERO));
        end

        // Hold reset, then release it on a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all requests taken, all verdicts back, then let the pipe empty
        wait (pending_ids.size() == 0 && !s_axis_tvalid);
        wait (expected_verdicts.size() == 0);
        repeat (2 * PipeLatency) @(posedge clk);
        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TimeoutNs);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: cpf_check_digit_validator.f
hdl/cpf_pkg.sv
hdl/cpf_dd_cell.sv
hdl/cpf_check.sv
hdl/cpf_check_digit_validator.sv
verif/tb_top.sv
